### hw/rtl/cslm_pkg.sv
package cslm_pkg;

   localparam int MAX_SCOPES_DEFAULT = 16;

   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 64;
   localparam int PREFIX_W = 8;
   localparam int HIT_W    = 4;
   localparam int STATUS_W = 2;

   localparam int V4_BITS   = 32;
   localparam int V6_BITS   = 128;
   localparam int HALF_BITS = 64;

   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MATCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Client address halves that mark an IPv4-mapped IPv6 address.
   localparam logic [ADDR_W-1:0] MAPPED_HIGH     = '0;
   localparam logic [31:0]       MAPPED_LOW_HIGH = 32'h0000_FFFF;

   typedef struct packed {
      logic                family;
      logic [ADDR_W-1:0]   net_high;
      logic [ADDR_W-1:0]   net_low;
      logic [PREFIX_W-1:0] prefix;
   } entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] masked_high;
      logic [ADDR_W-1:0] masked_low;
      logic              hit;
   } cmp_result_type;

   // Mask with p leading ones in 64 bits; p of 64 or more gives all ones.
   function automatic logic [ADDR_W-1:0] lead_ones(input logic [PREFIX_W-1:0] p);
      logic [ADDR_W-1:0] m;
      if (p >= PREFIX_W'(HALF_BITS)) begin
         m = '1;
      end else begin
         m = ~({ADDR_W{1'b1}} >> p[5:0]);
      end
      return m;
   endfunction

endpackage

### hw/rtl/cslm_channels.sv
interface cslm_req_if import cslm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic                family;
   logic [ADDR_W-1:0]   address_high;
   logic [ADDR_W-1:0]   address_low;
   logic [PREFIX_W-1:0] prefix_length;

   modport source (output valid, action, family, address_high, address_low, prefix_length,
                   input ready);
   modport sink (input valid, action, family, address_high, address_low, prefix_length,
                 output ready);
endinterface

interface cslm_rsp_if import cslm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                matched;
   logic [HIT_W-1:0]    hit_index;
   logic [STATUS_W-1:0] status;

   modport source (output valid, matched, hit_index, status, input ready);
   modport sink (input valid, matched, hit_index, status, output ready);
endinterface

### hw/rtl/cidr_scope_list_matcher.sv
// Sequence: a clear or unused item goes straight to the done state and an
// add through the add state; a match walks the stored scopes one entry per
// cycle up to the first hit or the last entry, then goes to the done state.
// Throughput: one item at a time; the next item is taken once the
// result has moved into the output register, which waits while a result is
// unread. Reset is synchronous, active high, empties the table, holds ready low.
module cidr_scope_list_matcher import cslm_pkg::*; #(
   parameter int MAX_SCOPES = MAX_SCOPES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   cslm_req_if.sink   req_chan,
   cslm_rsp_if.source rsp_chan
);

   // Index width for the table, and count width that also holds a full table.
   localparam int IDX_W = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
   localparam int CNT_W = $clog2(MAX_SCOPES + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADD  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   // The accepted item is held for the whole of its work.
   logic                family_ff;
   logic [ADDR_W-1:0]   client_hi_ff;
   logic [ADDR_W-1:0]   client_lo_ff;
   logic [PREFIX_W-1:0] prefix_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic                res_matched_ff, res_matched_in;
   logic [HIT_W-1:0]    res_hit_ff, res_hit_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_matched_ff, rsp_matched_in;
   logic [HIT_W-1:0]    rsp_hit_ff, rsp_hit_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // Scope table. It is written only at the fill count and its entries are used
   // only below it, so it needs no reset.
   entry_type        table_mem [MAX_SCOPES];
   entry_type        rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   entry_type        wr_data;

   cmp_result_type cmp;
   logic           accept;
   logic           prefix_over;
   logic           scan_last;

   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.matched   = rsp_matched_ff;
   assign rsp_chan.hit_index = rsp_hit_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // The one mask and compare unit serves both the add (masking the new
   // scope) and the match walk (masking the client with each stored prefix).
   cslm_mask_unit u_mask (
      .mask_family   ((state_ff == S_SCAN) ? rd_ff.family : family_ff),
      .mask_prefix   ((state_ff == S_SCAN) ? rd_ff.prefix : prefix_ff),
      .client_family (family_ff),
      .client_high   (client_hi_ff),
      .client_low    (client_lo_ff),
      .ref_high      (rd_ff.net_high),
      .ref_low       (rd_ff.net_low),
      .result        (cmp)
   );

   assign prefix_over = family_ff ? (prefix_ff > PREFIX_W'(V6_BITS)) :
                                    (prefix_ff > PREFIX_W'(V4_BITS));
   assign scan_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   assign wr_data.family   = family_ff;
   assign wr_data.net_high = cmp.masked_high;
   assign wr_data.net_low  = cmp.masked_low;
   assign wr_data.prefix   = prefix_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      res_matched_in = res_matched_ff;
      res_hit_in     = res_hit_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      rd_addr        = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // The walk reads entry zero while the item is being taken.
            if (accept) begin
               res_matched_in = 1'b0;
               res_hit_in     = '0;
               res_status_in  = STATUS_OK;
               idx_in         = '0;
               unique case (req_chan.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  ACT_ADD: begin
                     state_in = S_ADD;
                  end
                  ACT_MATCH: begin
                     state_in = (count_ff == '0) ? S_DONE : S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ADD: begin
            // A bad prefix is reported before a full table.
            if (prefix_over) begin
               res_status_in = STATUS_RANGE;
            end else if (count_ff == CNT_W'(MAX_SCOPES)) begin
               res_status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (cmp.hit) begin
               res_matched_in = 1'b1;
               res_hit_in     = HIT_W'(idx_ff);
               state_in       = S_DONE;
            end else if (scan_last) begin
               state_in = S_DONE;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = res_matched_ff;
               rsp_hit_in     = res_hit_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         family_ff    <= req_chan.family;
         client_hi_ff <= req_chan.address_high;
         client_lo_ff <= req_chan.address_low;
         prefix_ff    <= req_chan.prefix_length;
      end
      idx_ff         <= idx_in;
      res_matched_ff <= res_matched_in;
      res_hit_ff     <= res_hit_in;
      res_status_ff  <= res_status_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // The table write address is the fill count, which stays below the depth
   // whenever a write happens.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      rd_ff <= table_mem[rd_addr];
   end

endmodule

### hw/rtl/cslm_mask_unit.sv
// Shared prefix mask and compare unit. It masks the client address to the
// given prefix, and compares the masked value with a stored scope.
module cslm_mask_unit import cslm_pkg::*; (
   input  logic                mask_family,
   input  logic [PREFIX_W-1:0] mask_prefix,
   input  logic                client_family,
   input  logic [ADDR_W-1:0]   client_high,
   input  logic [ADDR_W-1:0]   client_low,
   input  logic [ADDR_W-1:0]   ref_high,
   input  logic [ADDR_W-1:0]   ref_low,
   output cmp_result_type      result
);

   logic [PREFIX_W-1:0] p_high;
   logic [PREFIX_W-1:0] p_low;
   logic [ADDR_W-1:0]   upper_mask;
   logic [ADDR_W-1:0]   lower_mask;
   logic                mapped;

   // For IPv4 the upper mask doubles as the 32-bit mask in its top half.
   always_comb begin
      if (mask_family) begin
         p_high = (mask_prefix > PREFIX_W'(HALF_BITS)) ? PREFIX_W'(HALF_BITS) : mask_prefix;
         p_low  = (mask_prefix > PREFIX_W'(HALF_BITS)) ?
                  PREFIX_W'(mask_prefix - PREFIX_W'(HALF_BITS)) : '0;
      end else begin
         p_high = (mask_prefix > PREFIX_W'(V4_BITS)) ? PREFIX_W'(V4_BITS) : mask_prefix;
         p_low  = '0;
      end
   end

   assign upper_mask = lead_ones(p_high);
   assign lower_mask = lead_ones(p_low);

   assign mapped = client_family && (client_high == MAPPED_HIGH) &&
                   (client_low[63:32] == MAPPED_LOW_HIGH);

   always_comb begin
      if (mask_family) begin
         result.masked_high = client_high & upper_mask;
         result.masked_low  = client_low & lower_mask;
         result.hit = client_family && !mapped &&
                      (result.masked_high == ref_high) && (result.masked_low == ref_low);
      end else begin
         result.masked_high = '0;
         result.masked_low  = {32'b0, client_low[31:0] & upper_mask[63:32]};
         result.hit = (!client_family || mapped) && (result.masked_low == ref_low);
      end
   end

endmodule

### hw/rtl/cslm_checker.sv
module cslm_checker import cslm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_matched,
   input logic [HIT_W-1:0]    rsp_hit_index,
   input logic [STATUS_W-1:0] rsp_status
);

   // After reset no result is offered.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched) &&
      $stable(rsp_hit_index) && $stable(rsp_status))
      else $error("stalled result changed");

   // An error status never comes with a hit.
   a_err_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> !rsp_matched && (rsp_hit_index == '0))
      else $error("error status reported with a hit");

   // A miss reports index zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> (rsp_hit_index == '0))
      else $error("miss with nonzero index");

   // The block works on one item at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

endmodule

bind cidr_scope_list_matcher cslm_checker u_cslm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_matched   (rsp_chan.matched),
   .rsp_hit_index (rsp_chan.hit_index),
   .rsp_status    (rsp_chan.status)
);

### test/cidr_scope_list_matcher_test.sv
module cidr_scope_list_matcher_test;
   import cslm_pkg::*;

   localparam int MAX_SCOPES = MAX_SCOPES_DEFAULT;

   // The package names the three actions that do something. The fourth code
   // is legal on the port and must leave the scope list alone.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int ITEMS_PER_RUN = 500;    // random items in each idling phase
   localparam int HOLD_CYCLES   = 200;    // the one long receiver hold-off
   localparam int DRAIN_CYCLES  = MAX_SCOPES + 8;
   // A slow but correct run stays well under this limit, even when the
   // receiver drops ready at its highest stall rate and a match walks all 16
   // scopes, and the limit leaves a wide margin over every item sent.
   localparam int CYCLE_LIMIT   = 400_000;

   // One item as it goes onto the request channel.
   typedef struct {
      logic [ACTION_W-1:0] action;
      logic                family;
      logic [ADDR_W-1:0]   ip_high;
      logic [ADDR_W-1:0]   ip_low;
      logic [PREFIX_W-1:0] prefix;
   } scope_request_type;

   // One item as it comes back on the response channel.
   typedef struct {
      logic                matched;
      logic [HIT_W-1:0]    hit_index;
      logic [STATUS_W-1:0] status;
   } match_verdict_type;

   // A row of the directed stimulus. Rows with known_verdict set carry the
   // response that is checked; the others are checked against the predictor.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                family;
      logic [ADDR_W-1:0]   ip_high;
      logic [ADDR_W-1:0]   ip_low;
      logic [PREFIX_W-1:0] prefix;
      logic [7:0]          repeats;
      logic                known_verdict;
      logic                matched;
      logic [HIT_W-1:0]    hit_index;
      logic [STATUS_W-1:0] status;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 27;

   // The scopes are stored in this order, so the index of each entry is
   // known: 0 is 10.0.0.0/8, 1 is 2001:db8::/32, 2 is 255.255.255.255/32,
   // 3 is the all-ones IPv6 host, 4 is fd00:0:0:1::/64, 5 is fd00:0:0:1:8000::/65,
   // 6 and 7 are the IPv4 and IPv6 catch-all scopes, 8 to 15 fill the list.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // A match on the empty list right after reset finds nothing.
      '{ACT_MATCH, 1'b0, 64'h0, 64'h0A01_0203, 8'd0, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK},
      // The unused action with every bit set does nothing.
      '{ACT_UNUSED, 1'b1, '1, '1, 8'd255, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK},
      // Prefix lengths just past each family's range, and the largest one.
      '{ACT_ADD, 1'b0, 64'h0, 64'h0A00_0000, 8'd33, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_RANGE},
      '{ACT_ADD, 1'b1, 64'h0, 64'h0, 8'd129, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_RANGE},
      '{ACT_ADD, 1'b1, '1, '1, 8'd255, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_RANGE},
      // IPv4 add with junk in the ignored upper bits.
      '{ACT_ADD, 1'b0, 64'hDEAD_BEEF_0BAD_F00D, 64'hFFFF_FFFF_0A12_3456, 8'd8, 8'd1,
        1'b1, 1'b0, 4'd0, STATUS_OK},
      '{ACT_ADD, 1'b1, 64'h2001_0DB8_FFFF_FFFF, 64'h1234, 8'd32, 8'd1,
        1'b1, 1'b0, 4'd0, STATUS_OK},
      '{ACT_ADD, 1'b0, 64'h0, 64'hFFFF_FFFF, 8'd32, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK},
      '{ACT_ADD, 1'b1, '1, '1, 8'd128, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK},
      // The boundary between the two address halves.
      '{ACT_ADD, 1'b1, 64'hFD00_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 8'd64, 8'd1,
        1'b1, 1'b0, 4'd0, STATUS_OK},
      '{ACT_ADD, 1'b1, 64'hFD00_0000_0000_0001, 64'h8000_0000_0000_0000, 8'd65, 8'd1,
        1'b1, 1'b0, 4'd0, STATUS_OK},
      // Mapped client against an IPv4 scope, IPv4 client with junk above
      // bit 31, plain IPv6 clients, the all-ones mapped client and a plain IPv4 client.
      '{ACT_MATCH, 1'b1, MAPPED_HIGH, {MAPPED_LOW_HIGH, 32'h0A09_0909}, 8'd0, 8'd1,
        1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b0, '1, 64'h1234_5678_0AFF_0001, 8'd0, 8'd1, 1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b1, 64'h2001_0DB8_0000_0000, 64'h1, 8'd0, 8'd1,
        1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b1, '1, '1, 8'd0, 8'd1, 1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b1, MAPPED_HIGH, {MAPPED_LOW_HIGH, 32'hFFFF_FFFF}, 8'd0, 8'd1,
        1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b1, 64'hFD00_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 8'd1,
        1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b0, 64'h0, 64'h0B00_0001, 8'd0, 8'd1, 1'b0, 1'b0, 4'd0, STATUS_OK},
      // Zero-length prefixes of both families.
      '{ACT_ADD, 1'b0, 64'h0, 64'h0, 8'd0, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK},
      '{ACT_ADD, 1'b1, 64'h0, 64'h0, 8'd0, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK},
      // The IPv6 catch-all must not take a mapped client; the IPv4 one does.
      '{ACT_MATCH, 1'b1, MAPPED_HIGH, {MAPPED_LOW_HIGH, 32'h0B00_0001}, 8'd0, 8'd1,
        1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b1, 64'h0, 64'h0000_FFFE_0000_0001, 8'd0, 8'd1,
        1'b0, 1'b0, 4'd0, STATUS_OK},
      // Fill the list, then overflow it, then show the range check wins.
      '{ACT_ADD, 1'b1, 64'h2001_0DB8_0000_0000, 64'h5555_0000_0000_0000, 8'd96, 8'd8,
        1'b0, 1'b0, 4'd0, STATUS_OK},
      '{ACT_ADD, 1'b0, 64'h0, 64'h0A00_0000, 8'd24, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_FULL},
      '{ACT_ADD, 1'b0, 64'h0, 64'h0, 8'd40, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_RANGE},
      // Clear, then a catch-all client finds nothing.
      '{ACT_CLEAR, 1'b0, 64'h0, 64'h0, 8'd0, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK},
      '{ACT_MATCH, 1'b0, 64'h0, 64'h0, 8'd0, 8'd1, 1'b1, 1'b0, 4'd0, STATUS_OK}
   };

   logic clock;
   logic reset;

   cslm_req_if req_chan ();
   cslm_rsp_if rsp_chan ();

   cidr_scope_list_matcher #(
      .MAX_SCOPES(MAX_SCOPES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Predictor state: its own copy of the scope list.
   entry_type   scope_store [MAX_SCOPES];
   int unsigned scope_count;

   match_verdict_type expected_verdicts [$];

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned sent_items;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit          hold_request = 1'b0;
   int unsigned hold_done = 0;

   // Tallies for the closing summary.
   int unsigned stored_count;
   int unsigned full_count;
   int unsigned range_count;
   int unsigned hit_count;
   int unsigned miss_count;
   int unsigned clear_count;
   int unsigned deep_hit_count;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Free-running cycle count; it also bounds the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles, %0d results still due",
                  $time, cycle_count, expected_verdicts.size());
         $display("FAIL");
         $finish;
      end
   end

   // Leading-ones masks of a given length. The IPv4 one is only called with
   // lengths up to 32, the IPv6 one with lengths up to 128.
   function automatic logic [31:0] v4_mask(input int unsigned len);
      return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (V4_BITS - len));
   endfunction

   function automatic logic [127:0] v6_mask(input int unsigned len);
      return (len == 0) ? 128'h0 : ({128{1'b1}} << (V6_BITS - len));
   endfunction

   // Works out the response to one accepted item and updates the scope list
   // the way the block must.
   function automatic match_verdict_type predict_verdict(input scope_request_type r);
      match_verdict_type v;
      int unsigned       limit;
      logic              mapped;
      logic              have_v4;
      logic              hit_now;
      entry_type         e;
      v.matched   = 1'b0;
      v.hit_index = '0;
      v.status    = STATUS_OK;
      case (r.action)
         ACT_CLEAR: begin
            scope_count = 0;
            clear_count++;
         end
         ACT_ADD: begin
            limit = r.family ? V6_BITS : V4_BITS;
            // The range check comes before the full check.
            if (r.prefix > limit) begin
               v.status = STATUS_RANGE;
               range_count++;
            end else if (scope_count >= MAX_SCOPES) begin
               v.status = STATUS_FULL;
               full_count++;
            end else begin
               e.family = r.family;
               e.prefix = r.prefix;
               if (r.family) begin
                  {e.net_high, e.net_low} = {r.ip_high, r.ip_low} & v6_mask(r.prefix);
               end else begin
                  e.net_high = '0;
                  e.net_low  = {32'h0, r.ip_low[31:0] & v4_mask(r.prefix)};
               end
               scope_store[scope_count] = e;
               scope_count++;
               stored_count++;
            end
         end
         ACT_MATCH: begin
            mapped  = r.family && r.ip_high == MAPPED_HIGH &&
                      r.ip_low[63:32] == MAPPED_LOW_HIGH;
            have_v4 = !r.family || mapped;
            for (int i = 0; i < int'(scope_count) && !v.matched; i++) begin
               e       = scope_store[i];
               hit_now = 1'b0;
               if (!e.family) begin
                  if (have_v4) begin
                     hit_now = (r.ip_low[31:0] & v4_mask(e.prefix)) == e.net_low[31:0];
                  end
               end else if (r.family && !mapped) begin
                  hit_now = ({r.ip_high, r.ip_low} & v6_mask(e.prefix)) ==
                            {e.net_high, e.net_low};
               end
               if (hit_now) begin
                  v.matched   = 1'b1;
                  v.hit_index = HIT_W'(i);
                  if (i >= MAX_SCOPES / 2) begin
                     deep_hit_count++;
                  end
               end
            end
            if (v.matched) begin
               hit_count++;
            end else begin
               miss_count++;
            end
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   // Random item. Most adds have legal prefixes with the extremes favored;
   // most matches are aimed at a stored scope, with the bits past its prefix
   // randomized and now and then one bit inside the prefix flipped to give a
   // near miss. The rest is noise: random clients, mapped clients, clears
   // and the unused action. Clears are rare enough that the list often fills.
   function automatic scope_request_type random_request();
      scope_request_type r;
      int unsigned       pick;
      int unsigned       limit;
      int unsigned       idx;
      int unsigned       plen;
      int unsigned       flip;
      logic [127:0]      keep;
      logic [127:0]      client;
      logic [31:0]       m4;
      logic [31:0]       v4;
      r.action  = ACT_MATCH;
      r.family  = 1'($urandom_range(0, 1));
      r.ip_high = {$urandom, $urandom};
      r.ip_low  = {$urandom, $urandom};
      r.prefix  = PREFIX_W'($urandom);
      pick      = $urandom_range(0, 199);
      if (pick < 3) begin
         r.action = ACT_CLEAR;
      end else if (pick < 6) begin
         r.action = ACT_UNUSED;
      end else if (pick < 86) begin
         r.action = ACT_ADD;
         limit    = r.family ? V6_BITS : V4_BITS;
         case ($urandom_range(0, 9))
            0: r.prefix = PREFIX_W'($urandom_range(limit + 1, 255));
            1: r.prefix = '0;
            2: r.prefix = PREFIX_W'(limit);
            default: r.prefix = PREFIX_W'($urandom_range(0, limit));
         endcase
      end else if (scope_count != 0 && $urandom_range(0, 3) != 0) begin
         idx  = $urandom_range(0, scope_count - 1);
         plen = scope_store[idx].prefix;
         if (scope_store[idx].family) begin
            keep   = v6_mask(plen);
            client = ({scope_store[idx].net_high, scope_store[idx].net_low} & keep) |
                     ({r.ip_high, r.ip_low} & ~keep);
            if (plen != 0 && $urandom_range(0, 4) == 0) begin
               flip         = V6_BITS - $urandom_range(1, plen);
               client[flip] = ~client[flip];
            end
            r.family              = 1'b1;
            {r.ip_high, r.ip_low} = client;
         end else begin
            m4 = v4_mask(plen);
            v4 = (scope_store[idx].net_low[31:0] & m4) | (r.ip_low[31:0] & ~m4);
            if (plen != 0 && $urandom_range(0, 4) == 0) begin
               flip     = V4_BITS - $urandom_range(1, plen);
               v4[flip] = ~v4[flip];
            end
            // Reach the IPv4 scope either directly or through a mapped client.
            if ($urandom_range(0, 1) == 1) begin
               r.family  = 1'b1;
               r.ip_high = MAPPED_HIGH;
               r.ip_low  = {MAPPED_LOW_HIGH, v4};
            end else begin
               r.family       = 1'b0;
               r.ip_low[31:0] = v4;
            end
         end
      end else if ($urandom_range(0, 2) == 0) begin
         r.family        = 1'b1;
         r.ip_high       = MAPPED_HIGH;
         r.ip_low[63:32] = MAPPED_LOW_HIGH;
      end
      return r;
   endfunction

   // Offers one item and returns at the edge where it is taken. The sender
   // idles between items at the current rate, except in the first quarter of
   // every 64 items, which go back to back. Valid gets only one assignment
   // per time step: it stays high from one item straight into the next.
   task automatic offer_request(input scope_request_type r);
      while (send_idle_pct != 0 && (sent_items % 64) >= 16 &&
             $urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.action        <= r.action;
      req_chan.family        <= r.family;
      req_chan.address_high  <= r.ip_high;
      req_chan.address_low   <= r.ip_low;
      req_chan.prefix_length <= r.prefix;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      sent_items++;
   endtask

   task automatic send_and_predict(input scope_request_type r);
      match_verdict_type v;
      offer_request(r);
      v = predict_verdict(r);
      expected_verdicts.insert(expected_verdicts.size(), v);
   endtask

   // Receiver. It stalls at the current rate outside a quiet window that recurs
   // with the free-running cycle count. Once asked, it holds ready low for a
   // long stretch while the sender keeps offering, so the block backs up.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && hold_done == 0) begin
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
            hold_done++;
         end else begin
            rsp_chan.ready <= !(recv_stall_pct != 0 && (cycle_count % 128) >= 24 &&
                                $urandom_range(0, 99) < recv_stall_pct);
            @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string field_name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
         error_count++;
      end
   endfunction

   // Every response taken is checked against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected response, matched %0d hit_index %0d status %0d",
                     $time, rsp_chan.matched, rsp_chan.hit_index, rsp_chan.status);
            error_count++;
         end else begin
            check_field("matched", expected_verdicts[0].matched, rsp_chan.matched);
            check_field("hit_index", expected_verdicts[0].hit_index, rsp_chan.hit_index);
            check_field("status", expected_verdicts[0].status, rsp_chan.status);
            void'(expected_verdicts.pop_front());
         end
      end
   end

   initial begin
      scope_request_type r;
      match_verdict_type v;
      directed_row_type  row;
      sent_items             = 0;
      scope_count            = 0;
      stored_count           = 0;
      full_count             = 0;
      range_count            = 0;
      hit_count              = 0;
      miss_count             = 0;
      clear_count            = 0;
      deep_hit_count         = 0;
      send_idle_pct          = 6;
      recv_stall_pct         = 73;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.action        <= ACT_CLEAR;
      req_chan.family        <= 1'b0;
      req_chan.address_high  <= '0;
      req_chan.address_low   <= '0;
      req_chan.prefix_length <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows first, under the first idling mix.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row       = directed_rows[i];
         r.action  = row.action;
         r.family  = row.family;
         r.ip_high = row.ip_high;
         r.ip_low  = row.ip_low;
         r.prefix  = row.prefix;
         for (int n = 0; n < int'(row.repeats); n++) begin
            offer_request(r);
            // The predictor always runs so that its scope list keeps up.
            v = predict_verdict(r);
            if (row.known_verdict) begin
               v.matched   = row.matched;
               v.hit_index = row.hit_index;
               v.status    = row.status;
            end
            expected_verdicts.insert(expected_verdicts.size(), v);
         end
      end

      // Random items in three phases: sender rarely idle and receiver mostly
      // stalled, then the reverse, then no idling at all. The long receiver
      // hold-off starts the last phase.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 6;
               recv_stall_pct = 73;
            end
            1: begin
               send_idle_pct  = 73;
               recv_stall_pct = 6;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_request   = 1'b1;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_RUN; n++) begin
            send_and_predict(random_request());
         end
      end
      req_chan.valid <= 1'b0;

      while (expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d scopes stored, %0d adds on a full list, %0d bad prefixes,",
               sent_items, stored_count, full_count, range_count);
      $display("%0d clears, %0d match hits (%0d in the upper half of the list),",
               clear_count, hit_count, deep_hit_count);
      $display("%0d misses, %0d long hold-off.", miss_count, hold_done);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### cidr_scope_list_matcher.f
hw/rtl/cslm_pkg.sv
hw/rtl/cslm_channels.sv
hw/rtl/cslm_mask_unit.sv
hw/rtl/cidr_scope_list_matcher.sv
hw/rtl/cslm_checker.sv
test/cidr_scope_list_matcher_test.sv
